### hw/rtl/rnp_pkg.sv
// Shared types, codes and helpers for the Roman numeral parser.
// No dependencies; every module of the block imports this package.
`default_nettype none

package rnp_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} result_item_t;

	localparam int DigitW = 11;
	localparam int AccW   = 33;

	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_TRAIL  = 3'd3;
	localparam logic [2:0] PH_BAD    = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MALFORM  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic              blank;
		logic              minus;
		logic              letter_n;
		logic              is_digit;
		logic [DigitW-1:0] digit;
	} char_class_t;

	// State as it stands after the last character of a string
	typedef struct packed {
		logic [2:0]           phase;
		logic                 lone_n;
		logic                 overflowed;
		logic                 negative;
		logic signed [AccW-1:0] sum;
		logic signed [AccW-1:0] part;
	} snap_t;

	// Magnitude above 2^31-1
	function automatic logic too_big(input logic signed [AccW-1:0] v);
		return (v[AccW-1] != v[AccW-2]) ||
			(v == {2'b11, {(AccW-2){1'b0}}});
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rnp_char_class.sv
// Character classifier: blank, sign characters and Roman digit values.
// Depends on rnp_pkg.
`default_nettype none

module rnp_char_class (
	input  wire logic [7:0]           char_code,
	output rnp_pkg::char_class_t      cls
);
	import rnp_pkg::*;

	logic [7:0] upper;

	always_comb begin
		// fold lowercase letters onto uppercase
		if (char_code >= 8'h61 && char_code <= 8'h7A) begin
			upper = char_code - 8'h20;
		end else begin
			upper = char_code;
		end

		cls.blank    = (char_code == CH_SPACE) ||
			(char_code >= CH_TAB && char_code <= CH_CR);
		cls.minus    = (char_code == CH_MINUS);
		cls.letter_n = (char_code == CH_N);
		cls.is_digit = 1'b1;
		unique case (upper)
			8'h49: cls.digit = 11'd1;
			8'h56: cls.digit = 11'd5;
			8'h58: cls.digit = 11'd10;
			8'h4C: cls.digit = 11'd50;
			8'h43: cls.digit = 11'd100;
			8'h44: cls.digit = 11'd500;
			8'h4D: cls.digit = 11'd1000;
			default: begin
				cls.digit    = '0;
				cls.is_digit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/rnp_scan.sv
// Per-character grammar and run-rule accumulator; holds the parse state
// and hands a snapshot of it to the finish stage on the last character.
// Depends on rnp_pkg and rnp_char_class.
`default_nettype none

module rnp_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic                item_valid_s1,
	input  wire rnp_pkg::text_item_t item_s1,
	output logic                     snap_valid_s2,
	output rnp_pkg::snap_t           snap_s2
);
	import rnp_pkg::*;

	char_class_t cls;

	logic [2:0]             phase_q, phase_n;
	logic                   negative_q, negative_n;
	logic [DigitW-1:0]      prev_q, prev_n;
	logic signed [AccW-1:0] part_q, part_n;
	logic signed [AccW-1:0] sum_q, sum_n;
	logic                   ovf_q, ovf_n;
	logic signed [AccW-1:0] digit_ext, run_part, run_sum;
	logic                   take;
	logic                   last;

	rnp_char_class u_class (
		.char_code (item_s1.char_code),
		.cls       (cls)
	);

	assign take      = advance && item_valid_s1;
	assign last      = item_s1.end_of_text;
	assign digit_ext = AccW'($signed({1'b0, cls.digit}));

	// run rule on the current part and sum
	always_comb begin
		run_part = part_q;
		run_sum  = sum_q;
		if (cls.digit == prev_q) begin
			run_part = part_q + digit_ext;
		end else if (prev_q < cls.digit) begin
			run_part = digit_ext - part_q;
		end else begin
			run_sum  = sum_q + part_q;
			run_part = digit_ext;
		end
	end

	always_comb begin
		phase_n    = phase_q;
		negative_n = negative_q;
		prev_n     = prev_q;
		part_n     = part_q;
		sum_n      = sum_q;
		ovf_n      = ovf_q;
		unique case (phase_q)
			PH_LEAD: begin
				if (cls.blank) begin
					phase_n = PH_LEAD;
				end else if (cls.minus || cls.letter_n) begin
					negative_n = 1'b1;
					phase_n    = PH_SIGNED;
				end else if (cls.is_digit) begin
					prev_n  = cls.digit;
					part_n  = digit_ext;
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_SIGNED: begin
				if (cls.blank) begin
					phase_n = PH_SIGNED;
				end else if (cls.is_digit) begin
					prev_n  = cls.digit;
					part_n  = digit_ext;
					phase_n = PH_DIGITS;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_DIGITS: begin
				if (cls.blank) begin
					phase_n = PH_TRAIL;
				end else if (cls.is_digit) begin
					// freeze the accumulators once overflow is seen
					if (!ovf_q) begin
						if (too_big(run_part) || too_big(run_sum)) begin
							ovf_n = 1'b1;
						end else begin
							part_n = run_part;
							sum_n  = run_sum;
							prev_n = cls.digit;
						end
					end
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_TRAIL: begin
				if (!cls.blank) begin
					phase_n = PH_BAD;
				end
			end
			default: phase_n = PH_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEAD;
			negative_q    <= 1'b0;
			prev_q        <= '0;
			part_q        <= '0;
			sum_q         <= '0;
			ovf_q         <= 1'b0;
			snap_valid_s2 <= 1'b0;
		end else if (advance) begin
			snap_valid_s2 <= take && last;
			if (take && last) begin
				// string done: back to the reset state
				phase_q    <= PH_LEAD;
				negative_q <= 1'b0;
				prev_q     <= '0;
				part_q     <= '0;
				sum_q      <= '0;
				ovf_q      <= 1'b0;
			end else if (take) begin
				phase_q    <= phase_n;
				negative_q <= negative_n;
				prev_q     <= prev_n;
				part_q     <= part_n;
				sum_q      <= sum_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			snap_s2.phase      <= phase_n;
			snap_s2.lone_n     <= (phase_q == PH_LEAD) && cls.letter_n;
			snap_s2.overflowed <= ovf_n;
			snap_s2.negative   <= negative_n;
			snap_s2.sum        <= sum_n;
			snap_s2.part       <= part_n;
		end
	end

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last |=> phase_q == PH_LEAD && !ovf_q && part_q == '0)
		else $error("parse state not cleared after last character");

	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!too_big(part_q) && !too_big(sum_q))
		else $error("accumulator beyond 31-bit magnitude");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(part_q) && $stable(sum_q))
		else $error("parse state moved while stalled");

endmodule

`default_nettype wire

### hw/rtl/rnp_finish.sv
// Final add, sign and status for one string; drives the result register.
// Depends on rnp_pkg.
`default_nettype none

module rnp_finish (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  snap_valid_s2,
	input  wire rnp_pkg::snap_t        snap_s2,
	output logic                       result_valid_q,
	output rnp_pkg::result_item_t      result_q
);
	import rnp_pkg::*;

	logic signed [AccW-1:0] total;
	result_item_t           res;

	assign total = snap_s2.sum + snap_s2.part;

	always_comb begin
		res.value  = '0;
		res.status = ST_OK;
		unique case (snap_s2.phase)
			PH_LEAD: res.status = ST_OK;
			PH_SIGNED: begin
				if (!snap_s2.lone_n) begin
					res.status = ST_MALFORM;
				end
			end
			PH_DIGITS, PH_TRAIL: begin
				if (snap_s2.overflowed || too_big(total)) begin
					res.status = ST_OVERFLOW;
				end else if (snap_s2.negative) begin
					res.value = -total[31:0];
				end else begin
					res.value = total[31:0];
				end
			end
			default: res.status = ST_MALFORM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= snap_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && snap_valid_s2) begin
			result_q <= res;
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_q.status == ST_OK ||
			result_q.status == ST_MALFORM || result_q.status == ST_OVERFLOW)
		else $error("result status outside defined codes");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.status != ST_OK |-> result_q.value == '0)
		else $error("nonzero value with error status");

	a_snap_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && snap_valid_s2 |=> result_valid_q)
		else $error("finished string lost before result register");

endmodule

`default_nettype wire

### hw/rtl/roman_numeral_parser_top.sv
// Roman numeral parser top level: input register and stall control.
// Depends on rnp_pkg, rnp_scan (with rnp_char_class) and rnp_finish.
//
// Usage:
//   text channel (text_valid/text_ready/text) carries one byte per transfer,
//   with end_of_text set on the last byte of a string. The result channel
//   (result_valid/result_ready/result) carries one value and status per
//   string, produced by the transfer that has end_of_text set.
//   Throughput is one character per cycle while the receiver takes results;
//   it is set by the parse-state update (classify, 33-bit add, range check).
//   The result of a string passes the input register, snapshot register and
//   result register in turn after the transfer of the last character.
//   A stalled receiver (result_valid high, result_ready low) freezes all
//   three stages; text_ready follows result_ready combinationally.
//   Reset clears the parse state and all valid flags; the block accepts
//   text from the first cycle after reset.
`default_nettype none

module roman_numeral_parser_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  text_valid,
	output logic                       text_ready,
	input  wire rnp_pkg::text_item_t   text,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output rnp_pkg::result_item_t      result
);
	import rnp_pkg::*;

	logic         advance;
	logic         item_valid_s1;
	text_item_t   item_s1;
	logic         snap_valid_s2;
	snap_t        snap_s2;

	// advance every stage whenever the result slot is free or drains
	assign advance    = !result_valid || result_ready;
	assign text_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (advance) begin
			item_valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && text_valid) begin
			item_s1 <= text;
		end
	end

	rnp_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.snap_valid_s2 (snap_valid_s2),
		.snap_s2       (snap_s2)
	);

	rnp_finish u_finish (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.snap_valid_s2  (snap_valid_s2),
		.snap_s2        (snap_s2),
		.result_valid_q (result_valid),
		.result_q       (result)
	);

	a_last_reaches_scan: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_valid_s1 && item_s1.end_of_text |=> snap_valid_s2)
		else $error("last character did not produce a snapshot");

	a_no_spurious_snap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_valid_s1 |=> !snap_valid_s2)
		else $error("snapshot without a character");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(item_valid_s1) && $stable(snap_valid_s2))
		else $error("pipeline moved while result stalled");

endmodule

`default_nettype wire
